// File: rtl/thgi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thgi_pkg
// Shared types, codes and helpers for the trace history ring.
// ----------------------------------------------------------------------------
package thgi_pkg;

  typedef enum logic [2:0] {
    ACT_WRITE      = 3'd0,
    ACT_EMPTY      = 3'd1,
    ACT_RPT_INTERP = 3'd2,
    ACT_RPT_PLAIN  = 3'd3,
    ACT_SKIP       = 3'd4,
    ACT_CLEAR      = 3'd5,
    ACT_READ       = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    CFG_MAX_DIST = 2'd0,
    CFG_SCROLL   = 2'd1
  } cfg_index_t;

  localparam logic [14:0] MAX_DIST_RESET = 15'd8192;
  localparam logic [4:0]  RC_SAT         = 5'd31;

  // divider operand widths: |delta * (k - i)| < 2^21, divisor k + 1 <= 31
  localparam int DIV_NW = 21;
  localparam int DIV_DW = 5;

  typedef struct packed {
    logic [2:0]         action;
    logic [5:0]         point_index;
    logic signed [15:0] intensity;
    logic signed [15:0] position;
    logic signed [15:0] extra_value;
    logic [5:0]         skip_count;
    logic [5:0]         line_age;
  } item_t;

  typedef struct packed {
    logic signed [15:0] read_intensity;
    logic signed [15:0] read_position;
    logic signed [15:0] read_extra;
  } result_t;

  typedef struct packed {
    logic signed [15:0] inten;
    logic signed [15:0] pos;
    logic signed [15:0] extra;
  } point_t;

  typedef enum logic [2:0] {
    A_NEW_PIDX = 3'd0,
    A_RDLINE   = 3'd1,
    A_HELD_J   = 3'd2,
    A_NEW_J    = 3'd3,
    A_COPY_J   = 3'd4,
    A_SWEEP    = 3'd5
  } addr_sel_t;

  typedef enum logic [2:0] {
    W_ZERO    = 3'd0,
    W_INPUT   = 3'd1,
    W_COPY    = 3'd2,
    W_NEG_ORG = 3'd3,
    W_NEG_UPD = 3'd4,
    W_INTERP  = 3'd5
  } wdata_sel_t;

  typedef struct packed {
    logic       load;
    logic       step_back;
    logic       hold;
    logic       rc_inc;
    logic       rc_clr;
    logic       j_clr;
    logic       j_inc;
    logic       i_clr;
    logic       i_inc;
    logic       sweep_clr;
    logic       sweep_inc;
    logic       newest_top;
    logic       mod_sum;
    logic       mod_skip;
    logic       mod_step;
    logic       skip_apply;
    logic       lat_o;
    logic       lat_u;
    logic       lat_p;
    logic       mul;
    logic       div_start;
    logic       rd_en;
    logic       wr_en;
    addr_sel_t  addr_sel;
    wdata_sel_t wdata_sel;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    pidx_zero;
    logic    pidx_ok;
    logic    pidx_last;
    logic    rc_interp;
    logic    new_eq_held;
    logic    mod_small;
    logic    j_last;
    logic    i_last;
    logic    sweep_last;
    logic    bad_int;
    logic    org_neg;
    logic    in_dist;
    logic    rd_neg;
    logic    div_done;
  } stat_t;

  // negate a negative intensity, saturating the most negative code
  function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
    logic signed [16:0] n;
    n = -{v[15], v};
    return (n > 17'sd32767) ? 16'sd32767 : n[15:0];
  endfunction

endpackage

// File: rtl/trace_history_ring_with_gap_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trace_history_ring_with_gap_interp
// History ring of trace lines with gap interpolation over repeated lines.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; one is worked
// at a time, and the single-port line store (one access per cycle) sets the
// timing. A read steps sum = newest + age + scroll down by LINES until it is
// below LINES, then reads the point, with the result on result for the one
// cycle that result_valid is high; the receiver cannot stall it, so capture
// it then. Skip reduces skip_count the same way; an empty line zeroes its
// points one by one, a repeat copies the held line point by point, and clear
// zeroes the whole store. Completing a line after k interpolating repeats
// shifts the k copies of each point with positive, in-range endpoints
// through the bit-serial divider. After reset a clearing pass zeroes the
// store with busy high; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module trace_history_ring_with_gap_interp import thgi_pkg::*; #(
  parameter int LINES      = 64,
  parameter int POINTS     = 64,
  parameter int MAX_REPEAT = 30
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  item_t       item,
  output logic        result_valid,
  output result_t     result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: decode the transaction and step the store accesses
  thgi_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid)
  );

  // store, pointers, config and interpolation arithmetic
  thgi_datapath #(
    .LINES      (LINES),
    .POINTS     (POINTS),
    .MAX_REPEAT (MAX_REPEAT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  // a result only appears inside a transaction
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy) else $error("result outside a transaction");

  // an accepted transaction holds off the next one
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accept did not raise busy");

  // reset starts the clearing pass
  a_reset_clear: assert property (@(posedge clk)
    rst |=> busy) else $error("no clearing pass after reset");

  // a result never follows straight on an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !result_valid) else $error("result too early");

endmodule

// File: rtl/thgi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thgi_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module thgi_div import thgi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic [DIV_NW-1:0] quo,
  output logic              done
);

  localparam int CW = $clog2(DIV_NW + 1);

  logic              running;
  logic [CW-1:0]     cnt;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dvs;
  logic [DIV_DW:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem, quo[DIV_NW-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_NW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dvs <= den;
    end else if (running) begin
      if (fits) begin
        rem_tmp_assign: begin
        end
        rem <= DIV_DW'(rem_sh - {1'b0, dvs});
        quo <= {quo[DIV_NW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DIV_DW-1:0];
        quo <= {quo[DIV_NW-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/thgi_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thgi_datapath
// Line store, pointers, counters, config registers and interpolation math.
// ----------------------------------------------------------------------------
module thgi_datapath import thgi_pkg::*; #(
  parameter int LINES      = 64,
  parameter int POINTS     = 64,
  parameter int MAX_REPEAT = 30
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  item_t       item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data,
  output result_t     result
);

  localparam int DEPTH = LINES * POINTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = $clog2(LINES);
  localparam int PW    = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int MW    = $clog2(LINES + 127);

  item_t              it;
  logic [LW-1:0]      newest;
  logic [LW-1:0]      held;
  logic [LW-1:0]      cl;
  logic [4:0]         rc;
  logic [4:0]         i;
  logic [PW-1:0]      j;
  logic [AW-1:0]      sweep;
  logic [MW-1:0]      modv;
  logic [14:0]        max_dist;
  logic [5:0]         scroll;
  point_t             o_reg, u_reg, p_reg, rdata;
  logic signed [22:0] prod;
  logic               prod_neg;
  logic [47:0]        mem [DEPTH];

  logic [LW-1:0]      line;
  logic [31:0]        pt;
  logic [31:0]        addr_lin;
  logic [AW-1:0]      addr;
  point_t             wdata;
  logic signed [16:0] dpos;
  logic [16:0]        dabs;
  logic [4:0]         rcmi;
  logic [22:0]        prod_abs;
  logic [DIV_NW-1:0]  quo;
  logic               div_done;
  logic signed [22:0] qs;
  logic signed [22:0] psum;
  logic signed [15:0] psat;
  logic [LW:0]        skip_wrap;

  function automatic logic [LW-1:0] back1(input logic [LW-1:0] v);
    return (v == '0) ? LW'(LINES - 1) : v - 1'b1;
  endfunction

  function automatic logic [LW-1:0] fwd1(input logic [LW-1:0] v);
    return (v == LW'(LINES - 1)) ? '0 : v + 1'b1;
  endfunction

  // address: line * POINTS + point, or the sweep counter in a clearing pass
  always_comb begin
    line = newest;
    pt   = 32'(it.point_index);
    case (cmd.addr_sel)
      A_NEW_PIDX: begin line = newest;           pt = 32'(it.point_index); end
      A_RDLINE:   begin line = modv[LW-1:0];     pt = 32'(it.point_index); end
      A_HELD_J:   begin line = held;             pt = 32'(j);              end
      A_NEW_J:    begin line = newest;           pt = 32'(j);              end
      A_COPY_J:   begin line = cl;               pt = 32'(j);              end
      default:    begin line = newest;           pt = 32'(j);              end
    endcase
    addr_lin = 32'(line) * POINTS + pt;
    addr     = (cmd.addr_sel == A_SWEEP) ? sweep : addr_lin[AW-1:0];
  end

  assign dpos     = {u_reg.pos[15], u_reg.pos} - {o_reg.pos[15], o_reg.pos};
  assign dabs     = dpos[16] ? 17'(-dpos) : 17'(dpos);
  assign rcmi     = rc - i;
  assign prod_abs = prod[22] ? 23'(-prod) : 23'(prod);
  assign qs       = prod_neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
  assign psum     = 23'(p_reg.pos) + qs;
  assign psat     = (psum > 23'sd32767) ? 16'sd32767 :
                    (psum < -23'sd32768) ? -16'sd32768 : psum[15:0];
  assign skip_wrap = (LW + 1)'(newest) + (LW + 1)'(LINES) - (LW + 1)'(modv);

  always_comb begin
    wdata = '0;
    case (cmd.wdata_sel)
      W_ZERO:    wdata = '0;
      W_INPUT:   wdata = '{inten: it.intensity, pos: it.position, extra: it.extra_value};
      W_COPY:    wdata = rdata;
      W_NEG_ORG: wdata = '{inten: neg_sat(o_reg.inten), pos: o_reg.pos, extra: o_reg.extra};
      W_NEG_UPD: wdata = '{inten: neg_sat(rdata.inten), pos: rdata.pos, extra: rdata.extra};
      W_INTERP:  wdata = '{inten: p_reg.inten, pos: psat, extra: p_reg.extra};
      default:   wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[addr] <= wdata;
    if (cmd.rd_en) rdata <= mem[addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      newest   <= LW'(LINES - 1);
      held     <= '0;
      rc       <= '0;
      sweep    <= '0;
      max_dist <= MAX_DIST_RESET;
      scroll   <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_MAX_DIST) max_dist <= cfg_data;
      if (cfg_we && cfg_index == CFG_SCROLL)   scroll   <= cfg_data[5:0];
      if (cmd.hold && rc == '0) held <= newest;
      if (cmd.rc_clr) rc <= '0;
      else if (cmd.rc_inc && rc != RC_SAT) rc <= rc + 1'b1;
      if (cmd.newest_top) newest <= LW'(LINES - 1);
      else if (cmd.step_back) newest <= back1(newest);
      else if (cmd.skip_apply) begin
        newest <= (newest >= modv[LW-1:0]) ? newest - modv[LW-1:0] : skip_wrap[LW-1:0];
      end
      if (cmd.sweep_clr) sweep <= '0;
      else if (cmd.sweep_inc) sweep <= sweep + 1'b1;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) it <= item;
    if (cmd.j_clr) j <= '0;
    else if (cmd.j_inc) j <= j + 1'b1;
    if (cmd.i_clr) begin
      i  <= '0;
      cl <= fwd1(newest);
    end else if (cmd.i_inc) begin
      i  <= i + 1'b1;
      cl <= fwd1(cl);
    end
    if (cmd.mod_sum) modv <= MW'(newest) + MW'(it.line_age) + MW'(scroll);
    else if (cmd.mod_skip) modv <= MW'(it.skip_count);
    else if (cmd.mod_step) modv <= modv - MW'(LINES);
    if (cmd.lat_o) o_reg <= rdata;
    if (cmd.lat_u) u_reg <= rdata;
    if (cmd.lat_p) p_reg <= rdata;
    if (cmd.mul) prod <= dpos * $signed({1'b0, rcmi});
    if (cmd.div_start) prod_neg <= prod[22];
  end

  thgi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (prod_abs[DIV_NW-1:0]),
    .den   (rc + 1'b1),
    .quo   (quo),
    .done  (div_done)
  );

  always_comb begin
    stat.action      = action_t'(it.action);
    stat.pidx_zero   = it.point_index == '0;
    stat.pidx_ok     = 32'(it.point_index) < POINTS;
    stat.pidx_last   = 32'(it.point_index) == POINTS - 1;
    stat.rc_interp   = (rc != '0) && (32'(rc) < MAX_REPEAT);
    stat.new_eq_held = newest == held;
    stat.mod_small   = 32'(modv) < LINES;
    stat.j_last      = j == PW'(POINTS - 1);
    stat.i_last      = i == rc - 1'b1;
    stat.sweep_last  = sweep == AW'(DEPTH - 1);
    stat.bad_int     = (o_reg.inten <= 16'sd0) || (u_reg.inten <= 16'sd0);
    stat.org_neg     = o_reg.inten < 16'sd0;
    stat.in_dist     = dabs <= {2'b00, max_dist};
    stat.rd_neg      = rdata.inten < 16'sd0;
    stat.div_done    = div_done;
  end

  assign result.read_intensity = stat.pidx_ok ? rdata.inten : 16'sd0;
  assign result.read_position  = stat.pidx_ok ? rdata.pos   : 16'sd0;
  assign result.read_extra     = stat.pidx_ok ? rdata.extra : 16'sd0;

endmodule

// File: rtl/thgi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thgi_ctrl
// Sequencer for the trace history ring: one transaction at a time.
// ----------------------------------------------------------------------------
module thgi_ctrl import thgi_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  result_valid
);

  typedef enum logic [25:0] {
    S_CLR     = 26'd1,
    S_IDLE    = 26'd2,
    S_DISP    = 26'd4,
    S_WR      = 26'd8,
    S_ZL      = 26'd16,
    S_CP_CHK  = 26'd32,
    S_CP_RD   = 26'd64,
    S_CP_WR   = 26'd128,
    S_SKIP    = 26'd256,
    S_RD_MOD  = 26'd512,
    S_RD_MEM  = 26'd1024,
    S_RD_OUT  = 26'd2048,
    S_IJ_RO   = 26'd4096,
    S_IJ_RU   = 26'd8192,
    S_IJ_LAT  = 26'd16384,
    S_IJ_CHK  = 26'd32768,
    S_IJ_NRD  = 26'd65536,
    S_IJ_NCHK = 26'd131072,
    S_IC_RO   = 26'd262144,
    S_IC_RU   = 26'd524288,
    S_IC_RP   = 26'd1048576,
    S_IC_MUL  = 26'd2097152,
    S_IC_DIV  = 26'd4194304,
    S_IC_WAIT = 26'd8388608,
    S_IC_WR   = 26'd16777216,
    S_NJ      = 26'd33554432
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLR;
    else     state <= state_next;
  end

  assign busy         = state != S_IDLE;
  assign result_valid = state == S_RD_OUT;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLR: begin
        cmd.wr_en     = 1'b1;
        cmd.addr_sel  = A_SWEEP;
        cmd.wdata_sel = W_ZERO;
        cmd.sweep_inc = 1'b1;
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        cmd.j_clr  = 1'b1;
        state_next = S_IDLE;
        case (stat.action)
          ACT_WRITE: begin
            cmd.step_back = stat.pidx_zero;
            state_next    = S_WR;
          end
          ACT_EMPTY: begin
            cmd.rc_clr    = 1'b1;
            cmd.step_back = 1'b1;
            state_next    = S_ZL;
          end
          ACT_RPT_INTERP, ACT_RPT_PLAIN: begin
            cmd.hold      = 1'b1;
            cmd.rc_inc    = stat.action == ACT_RPT_INTERP;
            cmd.step_back = 1'b1;
            state_next    = S_CP_CHK;
          end
          ACT_SKIP: begin
            cmd.rc_clr   = 1'b1;
            cmd.mod_skip = 1'b1;
            state_next   = S_SKIP;
          end
          ACT_CLEAR: begin
            cmd.newest_top = 1'b1;
            cmd.sweep_clr  = 1'b1;
            state_next     = S_CLR;
          end
          ACT_READ: begin
            cmd.mod_sum = 1'b1;
            state_next  = S_RD_MOD;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_WR: begin
        cmd.wr_en     = stat.pidx_ok;
        cmd.addr_sel  = A_NEW_PIDX;
        cmd.wdata_sel = W_INPUT;
        state_next    = S_IDLE;
        if (stat.pidx_last) begin
          if (stat.rc_interp) state_next = S_IJ_RO;
          else cmd.rc_clr = 1'b1;
        end
      end
      S_ZL: begin
        cmd.wr_en     = 1'b1;
        cmd.addr_sel  = A_NEW_J;
        cmd.wdata_sel = W_ZERO;
        cmd.j_inc     = 1'b1;
        if (stat.j_last) state_next = S_IDLE;
      end
      S_CP_CHK: begin
        state_next = stat.new_eq_held ? S_IDLE : S_CP_RD;
      end
      S_CP_RD: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = A_HELD_J;
        state_next   = S_CP_WR;
      end
      S_CP_WR: begin
        cmd.wr_en     = 1'b1;
        cmd.addr_sel  = A_NEW_J;
        cmd.wdata_sel = W_COPY;
        cmd.j_inc     = 1'b1;
        state_next    = stat.j_last ? S_IDLE : S_CP_RD;
      end
      S_SKIP: begin
        if (stat.mod_small) begin
          cmd.skip_apply = 1'b1;
          state_next     = S_IDLE;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      S_RD_MOD: begin
        if (stat.mod_small) state_next = S_RD_MEM;
        else cmd.mod_step = 1'b1;
      end
      S_RD_MEM: begin
        cmd.rd_en    = stat.pidx_ok;
        cmd.addr_sel = A_RDLINE;
        state_next   = S_RD_OUT;
      end
      S_RD_OUT: state_next = S_IDLE;
      S_IJ_RO: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = A_HELD_J;
        state_next   = S_IJ_RU;
      end
      S_IJ_RU: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = A_NEW_J;
        cmd.lat_o    = 1'b1;
        state_next   = S_IJ_LAT;
      end
      S_IJ_LAT: begin
        cmd.lat_u  = 1'b1;
        state_next = S_IJ_CHK;
      end
      S_IJ_CHK: begin
        if (stat.bad_int) begin
          cmd.wr_en     = stat.org_neg;
          cmd.addr_sel  = A_HELD_J;
          cmd.wdata_sel = W_NEG_ORG;
          state_next    = S_IJ_NRD;
        end else if (stat.in_dist) begin
          cmd.i_clr  = 1'b1;
          state_next = S_IC_RO;
        end else begin
          state_next = S_NJ;
        end
      end
      S_IJ_NRD: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = A_NEW_J;
        state_next   = S_IJ_NCHK;
      end
      S_IJ_NCHK: begin
        cmd.wr_en     = stat.rd_neg;
        cmd.addr_sel  = A_NEW_J;
        cmd.wdata_sel = W_NEG_UPD;
        state_next    = S_NJ;
      end
      S_IC_RO: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = A_HELD_J;
        state_next   = S_IC_RU;
      end
      S_IC_RU: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = A_NEW_J;
        cmd.lat_o    = 1'b1;
        state_next   = S_IC_RP;
      end
      S_IC_RP: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = A_COPY_J;
        cmd.lat_u    = 1'b1;
        state_next   = S_IC_MUL;
      end
      S_IC_MUL: begin
        cmd.lat_p  = 1'b1;
        cmd.mul    = 1'b1;
        state_next = S_IC_DIV;
      end
      S_IC_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = S_IC_WAIT;
      end
      S_IC_WAIT: begin
        if (stat.div_done) state_next = S_IC_WR;
      end
      S_IC_WR: begin
        cmd.wr_en     = 1'b1;
        cmd.addr_sel  = A_COPY_J;
        cmd.wdata_sel = W_INTERP;
        cmd.i_inc     = 1'b1;
        state_next    = stat.i_last ? S_NJ : S_IC_RO;
      end
      S_NJ: begin
        if (stat.j_last) begin
          cmd.rc_clr = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.j_inc  = 1'b1;
          state_next = S_IJ_RO;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: tb/trace_history_ring_with_gap_interp_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trace_history_ring_with_gap_interp_tb
// Self-checking bench for the trace history ring. The bench sends command
// transactions from a queue in random bursts and tracks the line store,
// the line pointer, the repeat bookkeeping and the registers in its own
// shadow copy. For every read it queues the point that must come back and
// checks each strobed result field by field. Most of the stimulus is whole
// lines joined by interpolating repeats. The rest is random commands.
// Registers are rewritten between phases while the ring sits idle.
// ----------------------------------------------------------------------------
module trace_history_ring_with_gap_interp_tb;
  import thgi_pkg::*;

  localparam int LINES      = 64;
  localparam int POINTS     = 64;
  localparam int MAX_REPEAT = 30;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [2:0] ACT_UNUSED = 3'd7;
  localparam logic [1:0] CFG_UNUSED = 2'd2;

  typedef enum logic [1:0] {K_ITEM, K_CFG, K_DRAIN} job_kind_t;

  typedef struct {
    job_kind_t   kind;
    item_t       cmd;
    logic [1:0]  idx;
    logic [14:0] data;
  } job_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  item_t       item;
  logic        result_valid;
  result_t     result;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [14:0] cfg_data;

  trace_history_ring_with_gap_interp #(
    .LINES(LINES), .POINTS(POINTS), .MAX_REPEAT(MAX_REPEAT)
  ) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow of the ring: three channels per point, pointer and repeat state.
  int ring_int [LINES*POINTS];
  int ring_pos [LINES*POINTS];
  int ring_ext [LINES*POINTS];
  int newest, rep_cnt, held, max_dist, scroll;

  job_t    work_q[$];
  result_t readback_q[$];

  int n_items;
  int errors;
  int cycles;
  int gap_left;
  int burst_left;
  int quiet_run;
  int base_pos [POINTS];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int sat16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int back_one(input int ln);
    return (ln == 0) ? LINES - 1 : ln - 1;
  endfunction

  function automatic int at(input int ln, input int pt);
    return (ln % LINES) * POINTS + (pt % POINTS);
  endfunction

  task automatic wipe_ring();
    for (int s = 0; s < LINES*POINTS; s++) begin
      ring_int[s] = 0;
      ring_pos[s] = 0;
      ring_ext[s] = 0;
    end
  endtask

  // Line just finished: shift the repeated copies toward the new positions.
  task automatic close_line();
    int o, u, d, ln, s;
    if (rep_cnt == 0) return;
    if (rep_cnt < MAX_REPEAT) begin
      for (int j = 0; j < POINTS; j++) begin
        o = at(held, j);
        u = at(newest, j);
        if (ring_int[o] <= 0 || ring_int[u] <= 0) begin
          // absent or marked endpoints: make them positive, origin first
          if (ring_int[o] < 0) ring_int[o] = sat16(-ring_int[o]);
          if (ring_int[u] < 0) ring_int[u] = sat16(-ring_int[u]);
          continue;
        end
        d = ring_pos[u] - ring_pos[o];
        if (d > max_dist || d < -max_dist) continue;
        for (int i = 0; i < rep_cnt; i++) begin
          ln = (newest + 1 + i) % LINES;
          s = at(ln, j);
          d = ring_pos[u] - ring_pos[o];
          ring_pos[s] = sat16(ring_pos[s] + (d * (rep_cnt - i)) / (rep_cnt + 1));
        end
      end
    end
    rep_cnt = 0;
  endtask

  // Advance the shadow by one accepted transaction; queue a read's answer.
  task automatic ring_accept(input item_t t);
    int s, pidx;
    result_t r;
    pidx = t.point_index;
    case (t.action)
      ACT_WRITE: begin
        if (pidx == 0) newest = back_one(newest);
        if (pidx < POINTS) begin
          s = at(newest, pidx);
          ring_int[s] = t.intensity;
          ring_pos[s] = t.position;
          ring_ext[s] = t.extra_value;
          if (pidx == POINTS - 1) close_line();
        end
      end
      ACT_EMPTY: begin
        rep_cnt = 0;
        newest = back_one(newest);
        for (int j = 0; j < POINTS; j++) begin
          s = at(newest, j);
          ring_int[s] = 0;
          ring_pos[s] = 0;
          ring_ext[s] = 0;
        end
      end
      ACT_RPT_INTERP, ACT_RPT_PLAIN: begin
        if (rep_cnt == 0) held = newest;
        if (t.action == ACT_RPT_INTERP && rep_cnt < 31) rep_cnt++;
        newest = back_one(newest);
        if (newest != held) begin
          for (int j = 0; j < POINTS; j++) begin
            ring_int[at(newest, j)] = ring_int[at(held, j)];
            ring_pos[at(newest, j)] = ring_pos[at(held, j)];
            ring_ext[at(newest, j)] = ring_ext[at(held, j)];
          end
        end
      end
      ACT_SKIP: begin
        rep_cnt = 0;
        newest = (newest + LINES - (t.skip_count % LINES)) % LINES;
      end
      ACT_CLEAR: begin
        wipe_ring();
        newest = LINES - 1;
      end
      ACT_READ: begin
        if (pidx < POINTS) begin
          s = at((newest + t.line_age + scroll) % LINES, pidx);
          r.read_intensity = 16'(ring_int[s]);
          r.read_position  = 16'(ring_pos[s]);
          r.read_extra     = 16'(ring_ext[s]);
        end else begin
          r = '0;
        end
        readback_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [14:0] data);
    if (idx == CFG_MAX_DIST) max_dist = data;
    else if (idx == CFG_SCROLL) scroll = data[5:0];
  endtask

  // ---------------------------------------------------------------- driver
  // Present queued transactions in bursts. Register writes and drain marks
  // wait until the ring has been quiet with nothing owed.
  always @(posedge clk) begin : drive
    logic fire;
    logic nxt_start;
    fire = start && !busy;
    nxt_start = start && !fire;
    cfg_we <= 1'b0;
    if (rst) begin
      nxt_start = 1'b0;
    end else begin
      if (fire) ring_accept(item);
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (work_q.size() > 0) begin
          if (work_q[0].kind == K_ITEM) begin
            item <= work_q[0].cmd;
            nxt_start = 1'b1;
            void'(work_q.pop_front());
            if (burst_left <= 1) begin
              burst_left <= $urandom_range(1, 24);
              gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
            end else begin
              burst_left <= burst_left - 1;
            end
          end else if (quiet_run >= 4 && !fire) begin
            if (work_q[0].kind == K_CFG) begin
              cfg_we <= 1'b1;
              cfg_index <= work_q[0].idx;
              cfg_data <= work_q[0].data;
              reg_write(work_q[0].idx, work_q[0].data);
              // hold off the next command until the write has landed
              gap_left <= 2;
            end
            void'(work_q.pop_front());
          end
        end
      end
    end
    start <= nxt_start;
  end

  // Count quiet cycles: no request, not busy, no read answer owed.
  always @(posedge clk) begin
    if (rst || start || busy || readback_q.size() != 0) quiet_run <= 0;
    else if (quiet_run < 1000) quiet_run <= quiet_run + 1;
  end

  // --------------------------------------------------------------- monitor
  always @(posedge clk) begin : watch
    result_t want;
    if (!rst && result_valid) begin
      if (readback_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", result);
      end else begin
        want = readback_q.pop_front();
        if (want.read_intensity !== result.read_intensity ||
            want.read_position !== result.read_position ||
            want.read_extra !== result.read_extra) begin
          errors++;
          if (errors <= 10)
            $display("read mismatch: exp int %0d pos %0d ext %0d, got int %0d pos %0d ext %0d",
                     want.read_intensity, want.read_position, want.read_extra,
                     result.read_intensity, result.read_position, result.read_extra);
        end
      end
    end
  end

  // ---------------------------------------------------------- watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("trace_history_ring_with_gap_interp_tb NOT OK");
      $finish;
    end
  end

  // -------------------------------------------------------------- stimulus
  task automatic send(input logic [2:0] act, input int pidx, input int inten,
                      input int pos, input int ext, input int skip, input int age);
    job_t j;
    j.kind = K_ITEM;
    j.cmd.action = act;
    j.cmd.point_index = 6'(pidx);
    j.cmd.intensity = 16'(inten);
    j.cmd.position = 16'(pos);
    j.cmd.extra_value = 16'(ext);
    j.cmd.skip_count = 6'(skip);
    j.cmd.line_age = 6'(age);
    j.idx = '0;
    j.data = '0;
    work_q.push_back(j);
    n_items++;
  endtask

  task automatic send_cfg(input logic [1:0] idx, input int data);
    job_t j;
    j.kind = K_DRAIN;
    j.cmd = '0;
    j.idx = '0;
    j.data = '0;
    work_q.push_back(j);
    j.kind = K_CFG;
    j.idx = idx;
    j.data = 15'(data);
    work_q.push_back(j);
  endtask

  task automatic send_noise();
    logic [2:0] act;
    act = 3'($urandom_range(0, 7));
    // keep full-store clears rare, they are slow
    if (act == ACT_CLEAR && $urandom_range(0, 9) != 0) act = ACT_READ;
    send(act, $urandom_range(0, 63), $urandom, $urandom, $urandom,
         $urandom_range(0, 63), $urandom_range(0, 63));
  endtask

  // Write one whole line whose positions mostly sit near the previous line.
  task automatic send_line();
    int inten, pos, span, pick;
    span = max_dist + 64;
    for (int j = 0; j < POINTS; j++) begin
      pick = $urandom_range(0, 39);
      if (pick == 0) inten = -32768;
      else if (pick < 3) inten = -int'($urandom_range(1, 32767));
      else if (pick == 3) inten = 0;
      else inten = $urandom_range(1, 32767);
      if ($urandom_range(0, 9) == 0) pos = $urandom;
      else pos = base_pos[j] + int'($urandom_range(0, 2 * span)) - span;
      pos = sat16(pos);
      base_pos[j] = pos;
      send(ACT_WRITE, j, inten, pos, $urandom, $urandom_range(0, 63),
           $urandom_range(0, 63));
    end
  endtask

  task automatic send_gap_group(input int k);
    send_line();
    for (int r = 0; r < k; r++)
      send($urandom_range(0, 7) == 0 ? ACT_RPT_PLAIN : ACT_RPT_INTERP,
           $urandom_range(0, 63), $urandom, $urandom, $urandom,
           $urandom_range(0, 63), $urandom_range(0, 63));
    send_line();
    repeat ($urandom_range(0, 4))
      send(ACT_READ, $urandom_range(0, 63), 0, 0, 0, 0, $urandom_range(0, k + 2));
  endtask

  initial begin : stim
    int phase, k;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    n_items = 0;
    gap_left = 0;
    burst_left = 1;
    wipe_ring();
    newest = LINES - 1;
    rep_cnt = 0;
    held = 0;
    max_dist = MAX_DIST_RESET;
    scroll = 0;
    for (int j = 0; j < POINTS; j++) base_pos[j] = 0;

    // directed: field extremes, every command, unused codes
    send(ACT_READ, 0, 0, 0, 0, 0, 0);
    send(ACT_WRITE, 0, 32767, 32767, 32767, 0, 0);
    send(ACT_WRITE, 63, -32768, -32768, -32768, 63, 63);
    send(ACT_WRITE, 62, -1, 16384, -1, 0, 0);
    send(ACT_READ, 0, 0, 0, 0, 0, 0);
    send(ACT_READ, 63, 0, 0, 0, 0, 0);
    send(ACT_READ, 62, 0, 0, 0, 0, 63);
    send(ACT_RPT_INTERP, 0, 0, 0, 0, 0, 0);
    send(ACT_RPT_PLAIN, 0, 0, 0, 0, 0, 0);
    send(ACT_READ, 63, 0, 0, 0, 0, 1);
    send(ACT_EMPTY, 0, 0, 0, 0, 0, 0);
    send(ACT_READ, 0, 0, 0, 0, 0, 0);
    send(ACT_SKIP, 0, 0, 0, 0, 0, 0);
    send(ACT_SKIP, 0, 0, 0, 0, 63, 0);
    send(ACT_SKIP, 0, 0, 0, 0, 1, 0);
    send(ACT_UNUSED, 63, -1, -1, -1, 63, 63);
    send(ACT_READ, 0, 0, 0, 0, 0, 4);
    send(ACT_CLEAR, 0, 0, 0, 0, 0, 0);
    send(ACT_READ, 63, 0, 0, 0, 0, 0);
    send_cfg(CFG_SCROLL, 63);
    send(ACT_READ, 0, 0, 0, 0, 0, 63);
    send_cfg(CFG_UNUSED, 32767);
    send_cfg(CFG_MAX_DIST, 0);
    send(ACT_READ, 1, 0, 0, 0, 0, 1);

    // random phases, each under its own register settings
    phase = 0;
    while (n_items < 1300) begin
      case (phase % 4)
        0: begin send_cfg(CFG_MAX_DIST, 32767); send_cfg(CFG_SCROLL, 0); end
        1: begin send_cfg(CFG_MAX_DIST, 0); send_cfg(CFG_SCROLL, 63); end
        2: begin send_cfg(CFG_MAX_DIST, MAX_DIST_RESET); send_cfg(CFG_SCROLL, 0); end
        default: begin
          send_cfg(CFG_MAX_DIST, $urandom_range(0, 32767));
          send_cfg(CFG_SCROLL, $urandom_range(0, 63));
        end
      endcase
      // registers apply at write time; the line shaping reads the bench copy
      max_dist = (phase % 4 == 0) ? 32767 : (phase % 4 == 1) ? 0 : MAX_DIST_RESET;
      repeat (3) begin
        if (n_items >= 1300) break;
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 8)) send_noise();
        end else begin
          k = $urandom_range(0, 4);
          // long gaps just inside the repeat limit in phase 1, at the limit in phase 2
          if (phase == 1) k = MAX_REPEAT - 1;
          if (phase == 2) k = MAX_REPEAT;
          send_gap_group(k);
        end
      end
      phase++;
    end
    max_dist = MAX_DIST_RESET;
    scroll = 0;
    max_dist = 0;

    // the queue is drained by the driver only after reset is released below
    @(posedge clk);
    // the bench copy is rebuilt by the driver; restart it cleanly
    wipe_ring();
    newest = LINES - 1;
    rep_cnt = 0;
    held = 0;
    max_dist = MAX_DIST_RESET;
    scroll = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (work_q.size() != 0 || start) @(posedge clk);
    while (readback_q.size() != 0 || quiet_run < 4) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && readback_q.size() == 0) begin
      $display("trace_history_ring_with_gap_interp_tb OK");
    end else begin
      $display("trace_history_ring_with_gap_interp_tb NOT OK");
    end
    $finish;
  end

endmodule
